// ===== src/mra_pkg.sv =====
// ----------------------------------------------------------------------------
// mra_pkg: shared types and constants for the maximal rectangle block
// Holds the sequencer state encoding, the stack command type and the fixed
// widths of the configuration register and of the area result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mra_pkg;

   // Row length register.
   localparam int unsigned ROW_LEN_W = 7;
   localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 7'd64;

   // Area result and its saturation limit.
   localparam int unsigned AREA_W = 19;
   localparam logic [AREA_W-1:0] AREA_LIMIT = 19'h7FFFF;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_UPDATE = 7'b0000010,
      ST_FETCH  = 7'b0000100,
      ST_LOAD   = 7'b0001000,
      ST_CMP    = 7'b0010000,
      ST_POP    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   // Command to the bar stack.
   typedef struct packed {
      logic push;
      logic pop;
   } stack_cmd_type;

endpackage

// ===== src/max_ones_rectangle_area.sv =====
// ----------------------------------------------------------------------------
// max_ones_rectangle_area: largest all-ones rectangle in a binary matrix
// Cells arrive one beat at a time in row-major order; the row length comes
// from a register. The block keeps a per-column height of consecutive ones
// and, after each full row, finds the largest rectangle under that
// histogram with a stack pass, keeping the running maximum. The beat that
// carries the last cell of a matrix produces one result beat with the area,
// after which heights and maximum are cleared. Each cell is accepted, then
// its height is read-modify-written in a MAX_COLS-deep memory before the
// next cell is taken. A cell that closes a row or ends a matrix then starts
// the histogram pass: each column is fetched, loaded and compared with the
// stack top, and each bar popped off the stack is sized in a pop step before
// the next compare, every bar being popped once, using the single stack and
// the one multiplier. The input is not ready during that pass. Heights
// need no clearing sweep: a valid bit per column makes an unwritten column
// read as zero, and all valid bits drop at once at the end of a matrix.
// A finished result waits in an output register; only a second result
// arriving before the first is taken holds the block back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_ones_rectangle_area #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration port.
   input  logic                           csr_wr_en,
   input  logic [mra_pkg::ROW_LEN_W-1:0]  csr_wr_data,
   // Cell channel.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cell_req,
   input  logic                           req_last_in_matrix,
   // Result channel.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mra_pkg::AREA_W-1:0]     rsp_max_area
);
   import mra_pkg::*;

   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int LEN_W    = $clog2(MAX_COLS + 1);
   localparam int CNT_W    = LEN_W + 1;
   localparam int HEIGHT_W = $clog2(MAX_ROWS + 1);
   localparam int PROD_W   = HEIGHT_W + LEN_W;
   localparam int ENTRY_W  = HEIGHT_W + COL_W;

   // Configuration and control state.
   logic [ROW_LEN_W-1:0] csr_row_length_ff;
   state_type            state_ff, state_in;
   logic [COL_W-1:0]     pos_ff, pos_in;
   logic [AREA_W-1:0]    best_ff, best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MAX_COLS-1:0]  hvalid_ff;

   // Payload registers.
   logic                 cell_ff, cell_in;
   logic                 last_ff, last_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;
   logic [HEIGHT_W-1:0]  cur_ff, cur_in;
   logic [COL_W-1:0]     start_ff, start_in;
   logic [PROD_W-1:0]    area_ff, area_in;
   logic [AREA_W-1:0]    rsp_area_ff, rsp_area_in;

   // Height memory with its registered read port.
   logic [HEIGHT_W-1:0]  heights_mem [MAX_COLS];
   logic [HEIGHT_W-1:0]  rd_data_ff;
   logic                 rd_valid_ff;
   logic [COL_W-1:0]     rd_addr;

   // Decoded values.
   logic [31:0]          row_len_wide;
   logic [LEN_W-1:0]     len_eff;
   logic                 row_done;
   logic                 idx_at_end;
   logic                 idx_zeroed;
   logic [HEIGHT_W-1:0]  old_height;
   logic [HEIGHT_W-1:0]  new_height;
   logic [AREA_W-1:0]    area_sat;
   logic                 clear_matrix;

   // Stack interface.
   stack_cmd_type        stack_cmd;
   logic [ENTRY_W-1:0]   push_data;
   logic [ENTRY_W-1:0]   top_data;
   logic                 stack_empty;
   logic [HEIGHT_W-1:0]  top_height;
   logic [COL_W-1:0]     top_start;

   mra_stack #(
      .DEPTH  (MAX_COLS),
      .DATA_W (ENTRY_W)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .stack_cmd   (stack_cmd),
      .push_data   (push_data),
      .top_data    (top_data),
      .stack_empty (stack_empty)
   );

   assign top_height = top_data[ENTRY_W-1 -: HEIGHT_W];
   assign top_start  = top_data[COL_W-1:0];

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_area = rsp_area_ff;

   // A row length of zero means one column; anything above the column
   // capacity is held at the capacity.
   assign row_len_wide = 32'(csr_row_length_ff);
   always_comb begin
      if (csr_row_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (row_len_wide > 32'(MAX_COLS)) begin
         len_eff = LEN_W'(MAX_COLS);
      end else begin
         len_eff = LEN_W'(csr_row_length_ff);
      end
   end

   assign row_done   = (CNT_W'(pos_ff) + CNT_W'(1)) >= CNT_W'(len_eff);
   assign idx_at_end = (idx_ff == len_eff);
   // When a matrix ends part-way through a row, the columns after the last
   // cell count as zero for the closing pass.
   assign idx_zeroed = last_ff && (idx_ff > LEN_W'(pos_ff));

   assign old_height = rd_valid_ff ? rd_data_ff : '0;
   always_comb begin
      if (!cell_ff) begin
         new_height = '0;
      end else if (old_height < HEIGHT_W'(MAX_ROWS)) begin
         new_height = old_height + HEIGHT_W'(1);
      end else begin
         new_height = old_height;
      end
   end

   assign area_sat = (32'(area_ff) > 32'(AREA_LIMIT)) ? AREA_LIMIT : AREA_W'(area_ff);

   // The read port follows the cell position while idle and the pass index
   // otherwise.
   assign rd_addr = (state_ff == ST_IDLE) ? pos_ff : COL_W'(idx_ff);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_area_in  = rsp_area_ff;
      cell_in      = cell_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      area_in      = area_ff;
      clear_matrix = 1'b0;
      stack_cmd    = '0;
      push_data    = {cur_ff, start_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cell_in  = req_cell_req;
               last_in  = req_last_in_matrix;
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            if (row_done || last_ff) begin
               idx_in   = '0;
               state_in = ST_FETCH;
            end else begin
               pos_in   = pos_ff + COL_W'(1);
               state_in = ST_IDLE;
            end
         end

         ST_FETCH: begin
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            if (idx_at_end || idx_zeroed) begin
               cur_in = '0;
            end else begin
               cur_in = old_height;
            end
            start_in = COL_W'(idx_ff);
            state_in = ST_CMP;
         end

         ST_CMP: begin
            if (!stack_empty && (top_height >= cur_ff)) begin
               // The popped bar spans from its start to just before idx.
               stack_cmd.pop = 1'b1;
               area_in  = PROD_W'(top_height) * PROD_W'(idx_ff - LEN_W'(top_start));
               start_in = top_start;
               state_in = ST_POP;
            end else if (idx_at_end) begin
               state_in = ST_FINISH;
            end else begin
               stack_cmd.push = (cur_ff != '0);
               idx_in   = idx_ff + LEN_W'(1);
               state_in = ST_FETCH;
            end
         end

         ST_POP: begin
            if (area_sat > best_ff) begin
               best_in = area_sat;
            end
            state_in = ST_CMP;
         end

         ST_FINISH: begin
            if (!last_ff) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end else if (!(rsp_valid_ff && !rsp_ready)) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = best_ff;
               best_in      = '0;
               pos_in       = '0;
               clear_matrix = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_row_length_ff <= ROW_LEN_RESET;
         state_ff          <= ST_IDLE;
         pos_ff            <= '0;
         best_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_row_length_ff <= csr_wr_data;
         end
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      start_ff    <= start_in;
      area_ff     <= area_in;
      rsp_area_ff <= rsp_area_in;
   end

   // Column valid bits: a column that has not been written since the last
   // clear reads as height zero.
   always_ff @(posedge clock) begin
      if (reset || clear_matrix) begin
         hvalid_ff <= '0;
      end else if (state_ff == ST_UPDATE) begin
         hvalid_ff[pos_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff  <= heights_mem[rd_addr];
      rd_valid_ff <= hvalid_ff[rd_addr];
      if (state_ff == ST_UPDATE) begin
         heights_mem[pos_ff] <= new_height;
      end
   end

   // A result beat only ever starts from the end of a matrix.
   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH) && $past(last_ff))
      else $error("result raised outside the end of a matrix");

   // The closing bar of height zero must have emptied the stack.
   a_stack_drained : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> stack_empty)
      else $error("histogram pass finished with bars left on the stack");

   // Every accepted cell goes straight to its height update.
   a_accept_update : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_UPDATE))
      else $error("accepted cell did not reach the height update");

   // Leaving a matrix clears the maximum and all column heights.
   a_matrix_clear : assert property (@(posedge clock) disable iff (reset)
      clear_matrix |=> (best_ff == '0) && (hvalid_ff == '0) && (pos_ff == '0))
      else $error("matrix state not cleared after the result");

endmodule

// ===== src/mra_stack.sv =====
// ----------------------------------------------------------------------------
// mra_stack: bar stack for the histogram pass
// The top entry lives in a register; the entries below it sit in a memory
// that is written on a push and read into a register on a pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mra_stack #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 19
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mra_pkg::stack_cmd_type stack_cmd,
   input  logic [DATA_W-1:0]      push_data,
   output logic [DATA_W-1:0]      top_data,
   output logic                   stack_empty
);
   import mra_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SP_W  = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] stack_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              reload_ff, reload_in;

   // After a pop the new top comes from the memory read register in the next cycle.
   assign top_data    = reload_ff ? rd_data_ff : top_ff;
   assign stack_empty = (sp_ff == '0);

   always_comb begin
      sp_in     = sp_ff;
      top_in    = top_data;
      reload_in = 1'b0;
      if (stack_cmd.push) begin
         top_in = push_data;
         sp_in  = sp_ff + SP_W'(1);
      end else if (stack_cmd.pop) begin
         sp_in     = sp_ff - SP_W'(1);
         reload_in = (sp_ff > SP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (stack_cmd.push && (sp_ff != '0)) begin
         stack_mem[IDX_W'(sp_ff - SP_W'(1))] <= top_data;
      end
      if (stack_cmd.pop && (sp_ff > SP_W'(1))) begin
         rd_data_ff <= stack_mem[IDX_W'(sp_ff - SP_W'(2))];
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff     <= '0;
         reload_ff <= 1'b0;
      end else begin
         sp_ff     <= sp_in;
         reload_ff <= reload_in;
      end
   end

endmodule
